/* hdl/rtd_pkg.sv */
// Shared types, constants and codes for the RTD table search / interpolation block.
// No dependencies; every other file imports this package.
`default_nettype none

package rtd_pkg;

   localparam int TABLE_ENTRIES = 1051;
   localparam int INDEX_OFFSET  = 200;

   localparam int IDX_W    = $clog2(TABLE_ENTRIES);
   localparam int RES_W    = 16;
   localparam int TEMP_W   = 15;
   localparam int STATUS_W = 2;
   localparam int NUM_W    = RES_W + 4;
   localparam int Q_W      = 4;
   localparam int CNT_W    = 2;
   localparam int TW       = 18;

   localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(TABLE_ENTRIES - 1);
   localparam logic [Q_W-1:0]   FRAC_MAX   = Q_W'(10);

   localparam logic signed [TEMP_W-1:0] TEMP_TOO_LOW  = TEMP_W'(-2000);
   localparam logic signed [TEMP_W-1:0] TEMP_TOO_HIGH = TEMP_W'(8500);
   localparam logic signed [TW-1:0]     TEMP_MIN      = TW'(-16384);
   localparam logic signed [TW-1:0]     TEMP_MAX      = TW'(16383);

   localparam logic CMD_CONVERT = 1'b0;
   localparam logic CMD_LOAD    = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_LOW  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_HIGH = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHK_LOW,
      S_CHK_HIGH,
      S_PROBE,
      S_DIV_INIT,
      S_DIV_STEP,
      S_DONE
   } rtd_state_type;

   typedef enum logic [2:0] {
      MID_HOLD,
      MID_ZERO,
      MID_LAST,
      MID_HALF,
      MID_PROBE
   } mid_sel_type;

   typedef struct packed {
      logic        capture;
      logic        load_wr;
      mid_sel_type mid_sel;
      logic        take_low;
      logic        take_high;
      logic        mark_low;
      logic        mark_high;
      logic        probe;
      logic        div_init;
      logic        div_step;
      logic        out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic below;
      logic above;
      logic search_done;
      logic div_last;
   } dp_status_type;

endpackage

`default_nettype wire

/* hdl/rtd_if.sv */
// Valid/ready channel interfaces for requests and responses.
// Depends on rtd_pkg for field widths.
`default_nettype none

interface rtd_req_if import rtd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             cmd;
   logic [IDX_W-1:0] entry_index;
   logic [RES_W-1:0] entry_value;
   logic [RES_W-1:0] resistance;

   modport source (output valid, cmd, entry_index, entry_value, resistance, input ready);
   modport sink   (input valid, cmd, entry_index, entry_value, resistance, output ready);
endinterface

interface rtd_rsp_if import rtd_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [TEMP_W-1:0] temperature;
   logic [STATUS_W-1:0]      status;

   modport source (output valid, temperature, status, input ready);
   modport sink   (input valid, temperature, status, output ready);
endinterface

`default_nettype wire

/* hdl/rtd_ctrl.sv */
// Controller FSM: sequences table writes, compare, binary search, division and response load.
// Depends on rtd_pkg; drives rtd_datapath through ctrl_cmd_type.
`default_nettype none

module rtd_ctrl import rtd_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic          req_cmd,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd
);

   rtd_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.mid_sel  = MID_HOLD;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_cmd == CMD_LOAD) begin
                  cmd.load_wr = 1'b1;
               end else begin
                  cmd.capture = 1'b1;
                  cmd.mid_sel = MID_ZERO;
                  state_in    = S_CHK_LOW;
               end
            end
         end
         S_CHK_LOW: begin
            cmd.take_low = 1'b1;
            if (status.below) begin
               cmd.mark_low = 1'b1;
               state_in     = S_DONE;
            end else begin
               cmd.mid_sel = MID_LAST;
               state_in    = S_CHK_HIGH;
            end
         end
         S_CHK_HIGH: begin
            cmd.take_high = 1'b1;
            if (status.above) begin
               cmd.mark_high = 1'b1;
               state_in      = S_DONE;
            end else begin
               cmd.mid_sel = MID_HALF;
               state_in    = status.search_done ? S_DIV_INIT : S_PROBE;
            end
         end
         S_PROBE: begin
            cmd.probe   = 1'b1;
            cmd.mid_sel = MID_PROBE;
            if (status.search_done) begin
               state_in = S_DIV_INIT;
            end
         end
         S_DIV_INIT: begin
            cmd.div_init = 1'b1;
            state_in     = S_DIV_STEP;
         end
         S_DIV_STEP: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && (!rsp_valid_ff || rsp_ready))
      |=> (state_ff == S_IDLE && rsp_valid_ff))
      else $error("response not loaded on leaving DONE");

   a_convert_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid && req_cmd == CMD_CONVERT)
      |=> (state_ff == S_CHK_LOW))
      else $error("convert transaction did not start search");

   a_div_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV_STEP && status.div_last) |=> (state_ff == S_DONE))
      else $error("division did not finish");
`endif

endmodule

`default_nettype wire

/* hdl/rtd_datapath.sv */
// Datapath: table memory, search bounds, restoring divider and response register.
// Depends on rtd_pkg; controlled by rtd_ctrl.
`default_nettype none

module rtd_datapath import rtd_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire ctrl_cmd_type     cmd,
   output dp_status_type         status,
   input  wire logic [IDX_W-1:0] req_entry_index,
   input  wire logic [RES_W-1:0] req_entry_value,
   input  wire logic [RES_W-1:0] req_resistance,
   output logic signed [TEMP_W-1:0] rsp_temperature,
   output logic [STATUS_W-1:0]   rsp_status
);

   logic [RES_W-1:0] table_mem [TABLE_ENTRIES];
   logic [RES_W-1:0] rd_data_ff;

   logic [RES_W-1:0]    r_ff, tlo_ff, thi_ff, den_ff;
   logic [IDX_W-1:0]    lo_ff, hi_ff, mid_ff;
   logic [IDX_W-1:0]    lo_in, hi_in, mid_in;
   logic [NUM_W-1:0]    rem_ff;
   logic [Q_W-1:0]      q_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [STATUS_W-1:0] st_ff;
   logic signed [TEMP_W-1:0] rsp_temperature_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   logic                go_low;
   logic [IDX_W:0]      probe_sum, bound_sum;
   logic [RES_W-1:0]    diff;
   logic [NUM_W-1:0]    num, den_shift, rem_sub;
   logic                rem_ge;
   logic [Q_W-1:0]      frac;
   logic signed [TW-1:0] idx_rel, temp_wide, temp_sat;
   logic signed [TEMP_W-1:0] temp_out;

   assign go_low    = r_ff < rd_data_ff;
   assign lo_in     = cmd.probe ? (go_low ? lo_ff : mid_ff) : lo_ff;
   assign hi_in     = cmd.probe ? (go_low ? mid_ff : hi_ff) : hi_ff;
   assign probe_sum = {1'b0, lo_in} + {1'b0, hi_in};
   assign bound_sum = {1'b0, lo_ff} + {1'b0, hi_ff};

   always_comb begin
      unique case (cmd.mid_sel)
         MID_HOLD:  mid_in = mid_ff;
         MID_ZERO:  mid_in = '0;
         MID_LAST:  mid_in = LAST_INDEX;
         MID_HALF:  mid_in = bound_sum[IDX_W:1];
         MID_PROBE: mid_in = probe_sum[IDX_W:1];
         default:   mid_in = mid_ff;
      endcase
   end

   assign status.below       = r_ff < rd_data_ff;
   assign status.above       = r_ff > rd_data_ff;
   assign status.search_done = (mid_in == lo_in);
   assign status.div_last    = (cnt_ff == '0);

   always_ff @(posedge clock) begin
      if (cmd.load_wr && (req_entry_index <= LAST_INDEX)) begin
         table_mem[req_entry_index] <= req_entry_value;
      end
      rd_data_ff <= table_mem[mid_in];
   end

   assign diff      = r_ff - tlo_ff;
   assign num       = (NUM_W'(diff) << 3) + (NUM_W'(diff) << 1);
   assign den_shift = NUM_W'(den_ff) << cnt_ff;
   assign rem_ge    = rem_ff >= den_shift;
   assign rem_sub   = rem_ff - den_shift;

   always_ff @(posedge clock) begin
      mid_ff <= mid_in;
      if (cmd.capture) begin
         r_ff  <= req_resistance;
         lo_ff <= '0;
         hi_ff <= LAST_INDEX;
         st_ff <= STATUS_OK;
      end
      if (cmd.take_low)  tlo_ff <= rd_data_ff;
      if (cmd.take_high) thi_ff <= rd_data_ff;
      if (cmd.mark_low)  st_ff  <= STATUS_LOW;
      if (cmd.mark_high) st_ff  <= STATUS_HIGH;
      if (cmd.probe) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
         if (go_low) thi_ff <= rd_data_ff;
         else        tlo_ff <= rd_data_ff;
      end
      if (cmd.div_init) begin
         q_ff   <= '0;
         cnt_ff <= CNT_W'(Q_W - 1);
         if (thi_ff > tlo_ff) begin
            rem_ff <= num;
            den_ff <= thi_ff - tlo_ff;
         end else begin
            rem_ff <= '0;
            den_ff <= RES_W'(1);
         end
      end
      if (cmd.div_step) begin
         q_ff   <= {q_ff[Q_W-2:0], rem_ge};
         cnt_ff <= cnt_ff - CNT_W'(1);
         if (rem_ge) rem_ff <= rem_sub;
      end
      if (cmd.out_load) begin
         rsp_temperature_ff <= temp_out;
         rsp_status_ff      <= st_ff;
      end
   end

   assign frac      = (q_ff > FRAC_MAX) ? FRAC_MAX : q_ff;
   assign idx_rel   = TW'(lo_ff) - TW'(INDEX_OFFSET);
   assign temp_wide = (idx_rel <<< 3) + (idx_rel <<< 1) + TW'(frac);

   always_comb begin
      priority if (temp_wide < TEMP_MIN) temp_sat = TEMP_MIN;
      else if (temp_wide > TEMP_MAX)     temp_sat = TEMP_MAX;
      else                               temp_sat = temp_wide;
   end

   always_comb begin
      unique case (st_ff)
         STATUS_LOW:  temp_out = TEMP_TOO_LOW;
         STATUS_HIGH: temp_out = TEMP_TOO_HIGH;
         default:     temp_out = temp_sat[TEMP_W-1:0];
      endcase
   end

   assign rsp_temperature = rsp_temperature_ff;
   assign rsp_status      = rsp_status_ff;

`ifndef ASSERT_OFF
   a_probe_inside: assert property (@(posedge clock) disable iff (reset)
      cmd.probe |-> (lo_ff < mid_ff && mid_ff < hi_ff))
      else $error("probe index outside search bounds");

   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (den_ff != '0))
      else $error("divider running with zero divisor");

   a_lower_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.div_init |-> (tlo_ff <= r_ff))
      else $error("lower bracket entry above reading");
`endif

endmodule

`default_nettype wire

/* hdl/rtd_table_search_interpolate.sv */
// Top level of the RTD resistance-to-temperature converter.
// Depends on rtd_pkg, rtd_if, rtd_ctrl and rtd_datapath.
//
//   channel  | direction | payload
//   req_ch   | in        | cmd, entry_index, entry_value, resistance
//   rsp_ch   | out       | temperature, status (one per convert)
//
// Load transaction: written straight into the table memory.
// Convert: accept, lower bound check, upper bound check, binary-search probes, divider
// init, 4 divide steps, response load; an out-of-range reading ends after its bound check.
// One binary-search probe per cycle through the table memory's registered read port.
// Table contents are undefined after reset; reset clears only control state.
// A new transaction is accepted while a response still waits in its output register;
// a finished convert then holds until that response is taken.
`default_nettype none

module rtd_table_search_interpolate import rtd_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   rtd_req_if.sink   req_ch,
   rtd_rsp_if.source rsp_ch
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   rtd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_cmd   (req_ch.cmd),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rtd_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_entry_index (req_ch.entry_index),
      .req_entry_value (req_ch.entry_value),
      .req_resistance  (req_ch.resistance),
      .rsp_temperature (rsp_ch.temperature),
      .rsp_status      (rsp_ch.status)
   );

endmodule

`default_nettype wire
